// ----- rtl/tms_pkg.sv -----
// Package with the shared types, codes and arithmetic helpers of the triangular solver.
package tms_pkg;

  localparam int MAX_N      = 8;
  localparam int MAX_RHS    = 8;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = VAL_W + FRAC_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int A_DEPTH    = MAX_N * MAX_N;
  localparam int X_DEPTH    = MAX_N * MAX_RHS;
  localparam int ADDR_W     = 6;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SIZE  = 3'd0,
    REG_RHS   = 3'd1,
    REG_UPPER = 3'd2,
    REG_TRANS = 3'd3,
    REG_UNIT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [2:0]              row;
    logic [2:0]              col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              out_row;
    logic [2:0]              out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    status;
    logic                    last;
  } out_item_t;

  // One stage of the restoring divider chain.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [VAL_W-1:0] den;
    logic [VAL_W:0]   rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_stage_t;

  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Floors a full product by the fraction width and saturates it.
  function automatic logic signed [VAL_W-1:0] sat_prod(input logic signed [2*VAL_W-1:0] p);
    logic signed [2*VAL_W-FRAC_W-1:0] sh;
    sh = p[2*VAL_W-1:FRAC_W];
    if (sh > 48'sh00007FFFFFFF) sat_prod = VMAX;
    else if (sh < -48'sh000080000000) sat_prod = VMIN;
    else sat_prod = sh[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] d;
    d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (d[VAL_W] != d[VAL_W-1]) sub_sat = d[VAL_W] ? VMIN : VMAX;
    else sub_sat = d[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] magn(input logic signed [VAL_W-1:0] v);
    magn = v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Applies the sign to a quotient magnitude and saturates it.
  function automatic logic signed [VAL_W-1:0] sat_quo(input logic [NUM_W-1:0] q,
                                                      input logic neg);
    logic [NUM_W-1:0] lim;
    lim = {{(NUM_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};
    if (neg) begin
      if (q > lim) sat_quo = VMIN;
      else sat_quo = ~q[VAL_W-1:0] + 1'b1;
    end else begin
      if (q >= lim) sat_quo = VMAX;
      else sat_quo = q[VAL_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/triangular_matrix_solve_top.sv -----
// Top level of the fixed-point triangular solver: stores, sequencer and divider chain.
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  tms_pkg::in_item_t
//  out_     output     out_valid/out_stall tms_pkg::out_item_t
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A load writes its store directly. A solve reads the pivot of each row, then per rhs column
// subtracts each off-diagonal term and divides by the pivot in the divider chain unless the
// diagonal is unit; then the results are emitted one at a time, held while out_stall is high.
// Reset is synchronous; the stores hold no reset value and must be loaded first.
// in_stall is high from the solve transfer until the last result transfer.
module triangular_matrix_solve_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tms_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tms_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_PIVW, S_COL, S_COLW, S_MRD, S_MW, S_MS,
    S_FIN, S_DIVW, S_NEXT, S_ORD, S_OLD, S_OWAIT
  } state_t;

  state_t state_r;

  logic [3:0] size_r, rhs_r;
  logic       upper_r, trans_r, unit_r;

  logic [3:0] n_r, m_r, ii_r, j_r, k_r, k1_r, orow_r, ocol_r;
  logic [2:0] i_r, i_cur;
  logic       fwd_r;
  logic signed [VAL_W-1:0]   s_r, piv_r;
  logic signed [2*VAL_W-1:0] p_r;
  out_item_t  out_r;
  logic       out_valid_r;

  logic              a_we, x_we;
  logic [ADDR_W-1:0] a_raddr, x_raddr, x_waddr;
  logic [VAL_W-1:0]  a_rdata, x_rdata, x_wdata;
  logic              in_xfer;
  logic [3:0]        n_cl, m_cl;
  logic signed [VAL_W-1:0] div_res;

  div_stage_t stg [DIV_STEPS+1];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign n_cl  = (size_r == 4'd0) ? 4'd1 : ((size_r > 4'(MAX_N)) ? 4'(MAX_N) : size_r);
  assign m_cl  = (rhs_r == 4'd0) ? 4'd1 : ((rhs_r > 4'(MAX_RHS)) ? 4'(MAX_RHS) : rhs_r);
  assign i_cur = fwd_r ? ii_r[2:0] : 3'(n_r - 4'd1 - ii_r);

  always_comb begin
    a_raddr = '0;
    x_raddr = '0;
    case (state_r)
      S_ROW:   a_raddr = {i_cur, i_cur};
      S_COL:   x_raddr = {i_r, j_r[2:0]};
      S_MRD: begin
        a_raddr = trans_r ? {k_r[2:0], i_r} : {i_r, k_r[2:0]};
        x_raddr = {k_r[2:0], j_r[2:0]};
      end
      S_ORD:   x_raddr = {orow_r[2:0], ocol_r[2:0]};
      default: ;
    endcase
  end

  always_comb begin
    a_we    = in_xfer && (in_data.operation == OP_LOAD_A);
    x_we    = 1'b0;
    x_waddr = {i_r, j_r[2:0]};
    x_wdata = s_r;
    case (state_r)
      S_IDLE: begin
        x_we    = in_xfer && (in_data.operation == OP_LOAD_B);
        x_waddr = {in_data.row, in_data.col};
        x_wdata = in_data.value;
      end
      S_FIN:   x_we = unit_r;
      S_DIVW: begin
        x_we    = stg[DIV_STEPS].valid;
        x_wdata = div_res;
      end
      default: ;
    endcase
  end

  tms_ram #(.WIDTH(VAL_W), .DEPTH(A_DEPTH)) u_a_ram (
    .clk(clk), .we(a_we), .waddr({in_data.row, in_data.col}), .wdata(in_data.value),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  tms_ram #(.WIDTH(VAL_W), .DEPTH(X_DEPTH)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  // The head of the divider chain is loaded only in the cycle that finishes a column.
  always_comb begin
    stg[0].valid = (state_r == S_FIN) && !unit_r;
    stg[0].neg   = s_r[VAL_W-1] ^ piv_r[VAL_W-1];
    stg[0].den   = magn(piv_r);
    stg[0].rem   = '0;
    stg[0].num   = {magn(s_r), {FRAC_W{1'b0}}};
    stg[0].quo   = '0;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    tms_div_cell u_cell (.clk(clk), .rst_n(rst_n), .stg_in(stg[g]), .stg_out(stg[g+1]));
  end

  assign div_res = sat_quo(stg[DIV_STEPS].quo, stg[DIV_STEPS].neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= 4'd8;
      rhs_r       <= 4'd1;
      upper_r     <= 1'b0;
      trans_r     <= 1'b0;
      unit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r <= '0; m_r <= '0; ii_r <= '0; j_r <= '0; k_r <= '0; k1_r <= '0;
      orow_r <= '0; ocol_r <= '0; i_r <= '0; fwd_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE:  size_r  <= cfg_data[3:0];
          REG_RHS:   rhs_r   <= cfg_data[3:0];
          REG_UPPER: upper_r <= cfg_data[0];
          REG_TRANS: trans_r <= cfg_data[0];
          REG_UNIT:  unit_r  <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_data.operation == OP_SOLVE) begin
            n_r     <= n_cl;
            m_r     <= m_cl;
            fwd_r   <= (upper_r == trans_r);
            ii_r    <= '0;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          i_r     <= i_cur;
          state_r <= S_PIVW;
        end
        S_PIVW: begin
          piv_r <= a_rdata;
          j_r   <= '0;
          if (!unit_r && a_rdata == '0) begin
            out_r       <= '{out_row: i_r, out_col: 3'd0, out_value: '0,
                             status: 1'b1, last: 1'b1};
            out_valid_r <= 1'b1;
            state_r     <= S_OWAIT;
          end else begin
            state_r <= S_COL;
          end
        end
        S_COL: begin
          k_r     <= fwd_r ? 4'd0 : {1'b0, i_r} + 4'd1;
          k1_r    <= fwd_r ? {1'b0, i_r} : n_r;
          state_r <= S_COLW;
        end
        S_COLW: begin
          s_r     <= x_rdata;
          state_r <= (k_r == k1_r) ? S_FIN : S_MRD;
        end
        S_MRD: state_r <= S_MW;
        S_MW: begin
          p_r     <= $signed(a_rdata) * $signed(x_rdata);
          state_r <= S_MS;
        end
        S_MS: begin
          s_r     <= sub_sat(s_r, sat_prod(p_r));
          k_r     <= k_r + 4'd1;
          state_r <= (k_r + 4'd1 == k1_r) ? S_FIN : S_MRD;
        end
        S_FIN:  state_r <= unit_r ? S_NEXT : S_DIVW;
        S_DIVW: if (stg[DIV_STEPS].valid) state_r <= S_NEXT;
        S_NEXT: begin
          if (j_r + 4'd1 == m_r) begin
            j_r <= '0;
            if (ii_r + 4'd1 == n_r) begin
              orow_r  <= '0;
              ocol_r  <= '0;
              state_r <= S_ORD;
            end else begin
              ii_r    <= ii_r + 4'd1;
              state_r <= S_ROW;
            end
          end else begin
            j_r     <= j_r + 4'd1;
            state_r <= S_COL;
          end
        end
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          out_r       <= '{out_row: orow_r[2:0], out_col: ocol_r[2:0], out_value: x_rdata,
                           status: 1'b0,
                           last: (orow_r + 4'd1 == n_r) && (ocol_r + 4'd1 == m_r)};
          out_valid_r <= 1'b1;
          state_r     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_r.last) begin
              state_r <= S_IDLE;
            end else begin
              if (ocol_r + 4'd1 == m_r) begin
                ocol_r <= '0;
                orow_r <= orow_r + 4'd1;
              end else begin
                ocol_r <= ocol_r + 4'd1;
              end
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // No result may be pending while the block takes new items.
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("result pending while idle");

  // A singular result always closes the solve.
  a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> out_data.last) else $error("singular not last");

  // The divider only delivers while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stg[DIV_STEPS].valid |-> (state_r == S_DIVW)) else $error("stray quotient");

endmodule

// ----- rtl/tms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tms_div_cell.sv -----
// One cell of the divider chain: retires one quotient bit and hands its state on.
module tms_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tms_pkg::div_stage_t stg_in,
  output tms_pkg::div_stage_t stg_out
);
  import tms_pkg::*;

  div_stage_t     stg_r;
  logic [VAL_W:0] rem_sh;
  logic           ge;

  always_comb begin
    rem_sh = {stg_in.rem[VAL_W-1:0], stg_in.num[NUM_W-1]};
    ge     = rem_sh >= {1'b0, stg_in.den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r.valid <= stg_in.valid;
      stg_r.neg   <= stg_in.neg;
      stg_r.den   <= stg_in.den;
      stg_r.rem   <= ge ? (rem_sh - {1'b0, stg_in.den}) : rem_sh;
      stg_r.num   <= {stg_in.num[NUM_W-2:0], 1'b0};
      stg_r.quo   <= {stg_in.quo[NUM_W-2:0], ge};
    end
  end

  assign stg_out = stg_r;

endmodule
